// ===== rtl/core/fnu_pkg.sv =====
// Package for the fuzzy norm unit: constants, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fnu_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    typedef enum logic [1:0] {
        CMD_COMPL = 2'd0,
        CMD_TNORM = 2'd1,
        CMD_SNORM = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        FAM_ZADEH     = 3'd0,
        FAM_HAMACHER  = 3'd1,
        FAM_ALGEBRAIC = 3'd2,
        FAM_EINSTEIN  = 3'd3,
        FAM_BOUNDED   = 3'd4,
        FAM_DRASTIC   = 3'd5,
        FAM_RSVD6     = 3'd6,
        FAM_RSVD7     = 3'd7
    } fam_t;
endpackage
`default_nettype wire

// ===== rtl/core/fnu_front.sv =====
// Front end: saturates inputs, forms the product and operands of each operation.
// Depends on fnu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fnu_front
    import fnu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             in_cmd,
    input  wire logic [FRAC_BITS:0]     in_a,
    input  wire logic [FRAC_BITS:0]     in_b,
    input  wire logic [2:0]             family,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    // {undef, direct, num, den}: direct means result is num, no quotient
    output logic                        out_direct,
    output logic                        out_undef,
    output logic [FRAC_BITS+1:0]        out_num,
    output logic [FRAC_BITS+1:0]        out_den
);
    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    // stage 1: saturated operands and raw product
    logic                s1_valid_reg;
    logic [1:0]          s1_cmd_reg;
    logic [2:0]          s1_fam_reg;
    logic [W-1:0]        s1_a_reg, s1_b_reg;
    logic [2*W-1:0]      s1_prod_reg;
    logic [W-1:0]        sa, sb;
    logic                s1_adv;

    // stage 2 (output) registers
    logic                s2_valid_reg;
    logic                s2_direct_reg, s2_undef_reg;
    logic [W:0]          s2_num_reg, s2_den_reg;
    logic                s2_adv;

    assign s2_adv   = !s2_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    assign sa = (in_a > ONE) ? ONE : in_a;
    assign sb = (in_b > ONE) ? ONE : in_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= in_valid;
        end
        if (s1_adv) begin
            s1_cmd_reg  <= in_cmd;
            s1_fam_reg  <= family;
            s1_a_reg    <= sa;
            s1_b_reg    <= sb;
            s1_prod_reg <= sa * sb;
        end
    end

    logic [W-1:0] p;
    logic [W+1:0] sum, t_alg, s_alg, two_p;
    logic         dir_next, und_next;
    logic [W:0]   num_next, den_next;
    logic [W-1:0] mn, mx;

    always_comb begin
        p     = s1_prod_reg[FRAC_BITS +: W];
        sum   = (W+2)'(s1_a_reg) + (W+2)'(s1_b_reg);
        t_alg = sum - (W+2)'(p);
        two_p = (W+2)'(p) << 1;
        s_alg = sum - two_p;
        mn    = (s1_a_reg < s1_b_reg) ? s1_a_reg : s1_b_reg;
        mx    = (s1_a_reg > s1_b_reg) ? s1_a_reg : s1_b_reg;
        dir_next = 1'b1;
        und_next = 1'b0;
        num_next = '0;
        den_next = (W+1)'(ONE);
        case (s1_cmd_reg)
            CMD_COMPL: num_next = (W+1)'(ONE - s1_a_reg);
            CMD_TNORM: begin
                case (s1_fam_reg)
                    FAM_HAMACHER: begin
                        if (t_alg == '0) begin
                            und_next = 1'b1;
                        end else begin
                            dir_next = 1'b0;
                            num_next = (W+1)'(p);
                            den_next = t_alg[W:0];
                        end
                    end
                    FAM_ALGEBRAIC: num_next = (W+1)'(p);
                    FAM_EINSTEIN: begin
                        dir_next = 1'b0;
                        num_next = (W+1)'(p);
                        // ranges ONE..2*ONE, needs the full W+1 bits
                        den_next = (W+1)'((W+2)'(ONE) * 2 - t_alg);
                    end
                    FAM_BOUNDED: num_next = (sum > (W+2)'(ONE))
                                          ? (W+1)'(sum - (W+2)'(ONE)) : '0;
                    FAM_DRASTIC: num_next = (s1_a_reg < ONE && s1_b_reg < ONE)
                                          ? '0 : (W+1)'(mn);
                    default: num_next = (W+1)'(mn);
                endcase
            end
            CMD_SNORM: begin
                case (s1_fam_reg)
                    FAM_HAMACHER: begin
                        if (p == ONE) begin
                            und_next = 1'b1;
                            num_next = (W+1)'(ONE);
                        end else begin
                            dir_next = 1'b0;
                            num_next = s_alg[W:0];
                            den_next = (W+1)'(ONE - p);
                        end
                    end
                    FAM_ALGEBRAIC: num_next = t_alg[W:0];
                    FAM_EINSTEIN: begin
                        dir_next = 1'b0;
                        num_next = sum[W:0];
                        den_next = (W+1)'(ONE) + (W+1)'(p);
                    end
                    FAM_BOUNDED: num_next = sum[W:0];
                    FAM_DRASTIC: num_next = (s1_a_reg != '0 && s1_b_reg != '0)
                                          ? (W+1)'(ONE) : (W+1)'(mx);
                    default: num_next = (W+1)'(mx);
                endcase
            end
            default: num_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_adv) begin
            s2_direct_reg <= dir_next;
            s2_undef_reg  <= und_next;
            s2_num_reg    <= num_next;
            s2_den_reg    <= den_next;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_direct = s2_direct_reg;
    assign out_undef  = s2_undef_reg;
    assign out_num    = s2_num_reg;
    assign out_den    = s2_den_reg;
endmodule
`default_nettype wire

// ===== rtl/core/fnu_queue.sv =====
// Small FIFO between front end and back end.
// Depends on fnu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fnu_queue
    import fnu_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    logic [WIDTH-1:0]    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   cnt_reg;
    logic                push, pop;

    assign in_ready  = cnt_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
        if (push) mem_reg[wr_reg] <= in_data;
    end
endmodule
`default_nettype wire

// ===== rtl/core/fnu_back.sv =====
// Back end: pipelined restoring divider (one quotient bit per stage) and saturation.
// Depends on fnu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fnu_back
    import fnu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_direct,
    input  wire logic                 in_undef,
    input  wire logic [FRAC_BITS+1:0] in_num,
    input  wire logic [FRAC_BITS+1:0] in_den,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [FRAC_BITS:0]        out_degree,
    output logic                      out_undef
);
    localparam int W  = FRAC_BITS + 1;
    localparam int NW = W + 1;            // numerator / divisor width
    localparam int QW = NW + FRAC_BITS;   // dividend (num << F) width
    localparam int NS = QW;               // one quotient bit per stage
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    logic               v_reg   [NS+1];
    logic               d_reg   [NS+1];
    logic               u_reg   [NS+1];
    logic [QW-1:0]      q_reg   [NS+1];  // shifting dividend / quotient
    logic [NW:0]        r_reg   [NS+1];
    logic [NW-1:0]      dv_reg  [NS+1];
    logic               adv;

    assign adv      = !v_reg[NS] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
        end
        if (adv) begin
            d_reg[0]  <= in_direct;
            u_reg[0]  <= in_undef;
            q_reg[0]  <= QW'(in_num) << FRAC_BITS;
            r_reg[0]  <= '0;
            dv_reg[0] <= in_den;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_div
        logic [NW:0] rs;
        logic [NW+1:0] diff;
        always_comb begin
            rs   = {r_reg[i][NW-1:0], q_reg[i][QW-1]};
            diff = (NW+2)'(rs) - (NW+2)'(dv_reg[i]);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (adv) begin
                d_reg[i+1]  <= d_reg[i];
                u_reg[i+1]  <= u_reg[i];
                dv_reg[i+1] <= dv_reg[i];
                if (d_reg[i]) begin
                    q_reg[i+1] <= q_reg[i];
                    r_reg[i+1] <= r_reg[i];
                end else if (!diff[NW+1]) begin
                    r_reg[i+1] <= diff[NW:0];
                    q_reg[i+1] <= {q_reg[i][QW-2:0], 1'b1};
                end else begin
                    r_reg[i+1] <= rs;
                    q_reg[i+1] <= {q_reg[i][QW-2:0], 1'b0};
                end
            end
        end
    end

    logic [QW-1:0] res;
    always_comb begin
        res = d_reg[NS] ? (q_reg[NS] >> FRAC_BITS) : q_reg[NS];
        out_degree = (res > QW'(ONE)) ? ONE : res[W-1:0];
    end
    assign out_valid = v_reg[NS];
    assign out_undef = u_reg[NS];
endmodule
`default_nettype wire

// ===== rtl/core/fuzzy_norm_unit.sv =====
// Fuzzy norm unit top level: front end, queue and divider back end.
// Depends on fnu_pkg, fnu_front, fnu_queue, fnu_back.
//
// Applies complement, t-norm or s-norm to two Q1.16 degrees (FRAC_BITS
// fractional bits) under the family in norm_family. One transaction is
// accepted per cycle while m_tready does not stall the pipeline; from
// accept to m_tvalid an item passes 2 front stages, the queue, and the
// divider input register plus 2*FRAC_BITS+2 one-bit-per-stage divider stages.
`timescale 1ns / 1ps
`default_nettype none
module fuzzy_norm_unit
    import fnu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_wdata,      // norm_family
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [((2*FRAC_BITS+11)/8)*8-1:0] s_tdata,  // cmd, a, b
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [((FRAC_BITS+8)/8)*8-1:0] m_tdata,   // degree
    output logic                      m_tuser         // undefined_case
);
    localparam int W   = FRAC_BITS + 1;
    localparam int QD  = 2 + 2*(W+1);
    localparam int MDW = ((FRAC_BITS+8)/8)*8;

    logic [2:0] fam_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) fam_reg <= FAM_ZADEH;
        else if (cfg_we) fam_reg <= cfg_wdata;
    end

    logic          f_valid, f_ready, f_dir, f_und;
    logic [W:0]    f_num, f_den;
    logic          q_valid, q_ready;
    logic [QD-1:0] q_data;
    logic [W-1:0]  b_degree;

    fnu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_a(s_tdata[2 +: W]), .in_b(s_tdata[2+W +: W]),
        .family(fam_reg),
        .out_valid(f_valid), .out_ready(f_ready),
        .out_direct(f_dir), .out_undef(f_und), .out_num(f_num), .out_den(f_den)
    );

    fnu_queue #(.WIDTH(QD)) u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready),
        .in_data({f_und, f_dir, f_num, f_den}),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    fnu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready),
        .in_direct(q_data[QD-2]), .in_undef(q_data[QD-1]),
        .in_num(q_data[2*(W+1)-1 -: W+1]), .in_den(q_data[W:0]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_degree(b_degree), .out_undef(m_tuser)
    );

    assign m_tdata = MDW'(b_degree);
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for fuzzy_norm_unit: table-driven directed items, then random
// streams per norm family, checked against an in-bench fixed-point norm calculator.
// Depends on fnu_pkg and the fuzzy_norm_unit RTL.
`timescale 1ns / 1ps
module tb;
    import fnu_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int SW = ((2*FB+11)/8)*8;
    localparam int MW = ((FB+8)/8)*8;
    localparam logic [63:0] ONE = 64'd1 << FB;
    localparam int DRAIN_CYCLES = 2 * FB + 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [FB:0] degree;
        logic        undef;
    } degree_res_t;

    typedef struct {
        fam_t        fam;
        cmd_t        cmd;
        logic [FB:0] a;
        logic [FB:0] b;
        bit          typed;   // expected result given in the row
        logic [FB:0] degree;
        logic        undef;
    } stim_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;     // cmd, a, b from bit 0 up; top bits zero
    logic m_tvalid;
    logic m_tready = 0;
    logic [MW-1:0] m_tdata;          // degree
    logic m_tuser;                   // undefined_case

    fuzzy_norm_unit DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    degree_res_t pending_degrees[$];
    fam_t cur_family = FAM_ZADEH;
    int errors = 0;
    bit quiet = 0;        // no idling in the last part
    bit long_hold_req = 0;
    int cycles = 0;

    function automatic logic [63:0] clip_one(logic [63:0] v);
        return v > ONE ? ONE : v;
    endfunction

    function automatic degree_res_t norm_calc(fam_t fam, cmd_t cmd, logic [FB:0] ain,
                                              logic [FB:0] bin);
        degree_res_t r;
        logic [63:0] a, b, p, den, d;
        a = clip_one(64'(ain));
        b = clip_one(64'(bin));
        p = (a * b) >> FB;
        r.undef = 0;
        d = 0;
        if (cmd == CMD_COMPL) begin
            d = ONE - a;
        end else if (cmd == CMD_TNORM) begin
            case (fam)
                FAM_HAMACHER: begin
                    den = a + b - p;
                    if (den == 0) r.undef = 1;
                    else d = clip_one((p << FB) / den);
                end
                FAM_ALGEBRAIC: d = p;
                FAM_EINSTEIN: d = clip_one((p << FB) / (2 * ONE - (a + b - p)));
                FAM_BOUNDED: d = (a + b > ONE) ? a + b - ONE : 0;
                FAM_DRASTIC: d = (a < ONE && b < ONE) ? 0 : (a < b ? a : b);
                default: d = a < b ? a : b;
            endcase
        end else if (cmd == CMD_SNORM) begin
            case (fam)
                FAM_HAMACHER: begin
                    den = ONE - p;
                    if (den == 0) begin
                        r.undef = 1;
                        d = ONE;
                    end else begin
                        d = clip_one(((a + b - 2 * p) << FB) / den);
                    end
                end
                FAM_ALGEBRAIC: d = clip_one(a + b - p);
                FAM_EINSTEIN: d = clip_one(((a + b) << FB) / (ONE + p));
                FAM_BOUNDED: d = clip_one(a + b);
                FAM_DRASTIC: d = (a > 0 && b > 0) ? ONE : (a > b ? a : b);
                default: d = a > b ? a : b;
            endcase
        end
        r.degree = d[FB:0];
        return r;
    endfunction

    // One transaction; the result is queued at the accepting edge.
    task automatic send_item(cmd_t cmd, logic [FB:0] a, logic [FB:0] b, bit typed,
                             logic [FB:0] xdeg, logic xundef);
        degree_res_t r;
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= SW'({b, a, cmd});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (typed) begin
            r.degree = xdeg;
            r.undef = xundef;
        end else begin
            r = norm_calc(cur_family, cmd, a, b);
        end
        pending_degrees.push_back(r);
    endtask

    // Idle until all results are back, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 0;
        while (pending_degrees.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_family(fam_t fam);
        drain();
        cfg_we <= 1;
        cfg_wdata <= fam;
        @(posedge aclk);
        cfg_we <= 0;
        cur_family = fam;
    endtask

    function automatic logic [FB:0] rand_degree();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ONE[FB:0];
            2: return $urandom_range(ONE + 1, (1 << (FB + 1)) - 1);
            3: return $urandom_range(0, 3);
            4: return ONE[FB:0] - $urandom_range(1, 3);
            default: return $urandom_range(0, ONE);
        endcase
    endfunction

    // Receiver: random stall bursts, one long hold on request.
    int stall_left = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (long_hold_req) begin
            long_hold_req = 0;
            stall_left = 300;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 0;
        end else if (quiet || $urandom_range(0, 5) != 0) begin
            m_tready <= 1;
        end else begin
            stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 0;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        degree_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_degrees.size() == 0) begin
                $display("%0t: unexpected result degree=%0d undef=%0b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                e = pending_degrees.pop_front();
                if (m_tdata !== MW'(e.degree)) begin
                    $display("%0t: degree mismatch expected %0d actual %0d",
                             $time, e.degree, m_tdata);
                    errors++;
                end
                if (m_tuser !== e.undef) begin
                    $display("%0t: undefined_case mismatch expected %0b actual %0b",
                             $time, e.undef, m_tuser);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    stim_row_t dir_rows[] = '{
        '{FAM_ZADEH, CMD_COMPL, 17'd0, 17'd99, 1, 17'd65536, 0},
        '{FAM_ZADEH, CMD_COMPL, 17'd65536, 17'd0, 1, 17'd0, 0},
        '{FAM_ZADEH, CMD_COMPL, 17'h1FFFF, 17'h1FFFF, 1, 17'd0, 0},
        '{FAM_ZADEH, CMD_NONE, 17'd500, 17'd700, 1, 17'd0, 0},
        '{FAM_ZADEH, CMD_TNORM, 17'h1FFFF, 17'd5, 1, 17'd5, 0},
        '{FAM_ZADEH, CMD_SNORM, 17'd0, 17'd0, 1, 17'd0, 0},
        '{FAM_HAMACHER, CMD_TNORM, 17'd0, 17'd0, 1, 17'd0, 1},
        '{FAM_HAMACHER, CMD_SNORM, 17'd65536, 17'd65536, 1, 17'd65536, 1},
        '{FAM_HAMACHER, CMD_TNORM, 17'd1234, 17'd40000, 0, 0, 0},
        '{FAM_HAMACHER, CMD_SNORM, 17'd30000, 17'd50000, 0, 0, 0},
        '{FAM_ALGEBRAIC, CMD_TNORM, 17'd65536, 17'd65536, 1, 17'd65536, 0},
        '{FAM_ALGEBRAIC, CMD_SNORM, 17'd12345, 17'd54321, 0, 0, 0},
        '{FAM_EINSTEIN, CMD_TNORM, 17'd40000, 17'd50000, 0, 0, 0},
        '{FAM_EINSTEIN, CMD_TNORM, 17'd0, 17'd0, 1, 17'd0, 0},
        '{FAM_EINSTEIN, CMD_SNORM, 17'd40000, 17'd50000, 0, 0, 0},
        '{FAM_BOUNDED, CMD_TNORM, 17'd30000, 17'd30000, 1, 17'd0, 0},
        '{FAM_BOUNDED, CMD_SNORM, 17'd40000, 17'd40000, 1, 17'd65536, 0},
        '{FAM_DRASTIC, CMD_TNORM, 17'd65535, 17'd65535, 1, 17'd0, 0},
        '{FAM_DRASTIC, CMD_SNORM, 17'd1, 17'd1, 1, 17'd65536, 0},
        '{FAM_DRASTIC, CMD_TNORM, 17'd65536, 17'd777, 1, 17'd777, 0},
        '{FAM_RSVD7, CMD_TNORM, 17'd100, 17'd200, 1, 17'd100, 0},
        '{FAM_RSVD7, CMD_SNORM, 17'd100, 17'd200, 1, 17'd200, 0},
        '{FAM_RSVD6, CMD_SNORM, 17'd5, 17'd9, 1, 17'd9, 0}
    };

    initial begin
        fam_t fam_order[8] = '{FAM_HAMACHER, FAM_EINSTEIN, FAM_ALGEBRAIC, FAM_BOUNDED,
                               FAM_DRASTIC, FAM_RSVD6, FAM_ZADEH, FAM_HAMACHER};
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        set_family(FAM_ZADEH);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].fam != cur_family) set_family(dir_rows[i].fam);
            send_item(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
                      dir_rows[i].degree, dir_rows[i].undef);
        end

        for (int ph = 0; ph < 8; ph++) begin
            set_family(fam_order[ph]);
            if (ph == 7) quiet = 1;
            if (ph == 2) long_hold_req = 1;   // fill the queue, stall the input
            for (int n = 0; n < 85; n++)
                send_item(cmd_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)),
                          rand_degree(), rand_degree(), 0, 0, 0);
        end
        drain();

        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
